[rtl/anx_pkg.sv]
// ----------------------------------------------------------------------------
// anx_pkg
// Shared types, codes and header-type helpers for the Annex-B NAL unit
// extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package anx_pkg;

    // result field widths, fixed by the output format
    localparam int OFFSET_W = 32;
    localparam int LENGTH_W = 32;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // result kinds
    localparam logic KIND_UNIT    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // codec codes (codec_select and summary codec)
    localparam logic [1:0] CODEC_NONE = 2'd0;
    localparam logic [1:0] CODEC_AVC  = 2'd1;
    localparam logic [1:0] CODEC_HEVC = 2'd2;

    // start code bytes and lengths
    localparam logic [7:0] SC_BYTE      = 8'h01;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;
    localparam logic [2:0] SC_LEN_SHORT = 3'd3;
    localparam logic [2:0] SC_LEN_LONG  = 3'd4;
    localparam logic [2:0] SC_LEN_NONE  = 3'd0;

    // parameter-set header types
    localparam logic [4:0] AVC_SPS  = 5'd7;
    localparam logic [4:0] AVC_PPS  = 5'd8;
    localparam logic [5:0] HEVC_VPS = 6'd32;
    localparam logic [5:0] HEVC_PPS = 6'd34;

    typedef struct packed {
        logic                kind;
        logic [OFFSET_W-1:0] unit_offset;
        logic [LENGTH_W-1:0] unit_length;
        logic [2:0]          start_code_len;
        logic [4:0]          avc_type;
        logic [5:0]          hevc_type;
        logic [1:0]          codec;
        logic                overflow;
        logic                last;
    } anx_result_t;

    typedef struct packed {
        logic rec_valid;
        logic sum_valid;
    } anx_push_t;

    function automatic logic [4:0] avc_type_of(input logic [7:0] hdr);
        return hdr[4:0];
    endfunction

    function automatic logic [5:0] hevc_type_of(input logic [7:0] hdr);
        return hdr[6:1];
    endfunction

    // first parameter-set unit decides; H.265 is checked before H.264
    function automatic logic [1:0] detect_codec(
        input logic [1:0] cur,
        input logic       len_ge2,
        input logic [7:0] hdr
    );
        logic [4:0] avc;
        logic [5:0] hevc;
        avc  = avc_type_of(hdr);
        hevc = hevc_type_of(hdr);
        if (cur != CODEC_NONE)
            return cur;
        else if (len_ge2 && hevc >= HEVC_VPS && hevc <= HEVC_PPS)
            return CODEC_HEVC;
        else if (avc == AVC_SPS || avc == AVC_PPS)
            return CODEC_AVC;
        else
            return CODEC_NONE;
    endfunction

endpackage

`default_nettype wire

[rtl/anx_parser.sv]
// ----------------------------------------------------------------------------
// anx_parser
// Start-code tracker: one byte per take, produces at most one unit record
// and one summary per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module anx_parser #(
    parameter int POS_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 take,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 end_of_buffer,
    input  wire logic [1:0]           codec_select,
    output anx_pkg::anx_push_t        push,
    output anx_pkg::anx_result_t      rec_item,
    output anx_pkg::anx_result_t      sum_item
);
    import anx_pkg::*;

    localparam int PW = POS_BITS + 1;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    logic [POS_BITS-1:0] pos_reg;
    logic [1:0]          zero_run_reg;
    logic                unit_open_reg;
    logic [PW-1:0]       unit_start_reg;
    logic [7:0]          fpb_reg;
    logic [1:0]          det_reg;
    logic                sat_reg;
    logic [2:0]          code_len_reg;

    logic [POS_BITS-1:0] pos_next;
    logic [1:0]          zero_run_next;
    logic                unit_open_next;
    logic [PW-1:0]       unit_start_next;
    logic [7:0]          fpb_next;
    logic [1:0]          det_next;
    logic                sat_next;
    logic [2:0]          code_len_next;

    logic [7:0]    fpb_cur;
    logic          is_sc;
    logic [2:0]    sc_len;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] pos_inc;
    logic [PW-1:0] back;
    logic [PW-1:0] code_start;
    logic [PW-1:0] close_end;
    logic          close_ok;
    logic [PW-1:0] close_len;
    logic [1:0]    sum_codec;

    always_comb
    begin
        pos_ext = {1'b0, pos_reg};
        pos_inc = pos_ext + PW'(1);

        // first payload byte arrives while the unit is open at its start index
        fpb_cur = (unit_open_reg && pos_ext == unit_start_reg) ? data_byte : fpb_reg;

        is_sc  = (data_byte == SC_BYTE) && (zero_run_reg >= 2'd2);
        sc_len = (zero_run_reg == 2'd3) ? SC_LEN_LONG : SC_LEN_SHORT;
        back   = PW'(sc_len - 3'd1);
        code_start = (pos_ext >= back) ? (pos_ext - back) : '0;

        // a start code closes at its first zero; otherwise end of buffer closes
        close_end = is_sc ? code_start : pos_inc;
        close_ok  = unit_open_reg && (close_end > unit_start_reg)
                    && (is_sc || end_of_buffer);
        close_len = close_end - unit_start_reg;

        det_next = close_ok ? detect_codec(det_reg, close_len >= PW'(2), fpb_cur)
                            : det_reg;

        unique case (codec_select)
            CODEC_AVC:  sum_codec = CODEC_AVC;
            CODEC_HEVC: sum_codec = CODEC_HEVC;
            default:    sum_codec = (det_next != CODEC_NONE) ? det_next : CODEC_AVC;
        endcase

        sat_next = sat_reg || (pos_reg == POS_MAX);
        pos_next = (pos_reg == POS_MAX) ? POS_MAX : pos_inc[POS_BITS-1:0];

        if (is_sc)
            zero_run_next = 2'd0;
        else if (data_byte == ZERO_BYTE)
            zero_run_next = (zero_run_reg == 2'd3) ? 2'd3 : zero_run_reg + 2'd1;
        else
            zero_run_next = 2'd0;

        unit_open_next  = is_sc ? 1'b1 : unit_open_reg;
        unit_start_next = is_sc ? pos_inc : unit_start_reg;
        fpb_next        = is_sc ? ZERO_BYTE : fpb_cur;
        code_len_next   = is_sc ? sc_len : code_len_reg;

        rec_item.kind           = KIND_UNIT;
        rec_item.unit_offset    = OFFSET_W'(unit_start_reg);
        rec_item.unit_length    = LENGTH_W'(close_len);
        rec_item.start_code_len = code_len_reg;
        rec_item.avc_type       = avc_type_of(fpb_cur);
        rec_item.hevc_type      = hevc_type_of(fpb_cur);
        rec_item.codec          = CODEC_NONE;
        rec_item.overflow       = 1'b0;
        rec_item.last           = !end_of_buffer;

        sum_item.kind           = KIND_SUMMARY;
        sum_item.unit_offset    = '0;
        sum_item.unit_length    = '0;
        sum_item.start_code_len = SC_LEN_NONE;
        sum_item.avc_type       = '0;
        sum_item.hevc_type      = '0;
        sum_item.codec          = sum_codec;
        sum_item.overflow       = sat_next;
        sum_item.last           = 1'b1;

        push.rec_valid = take && close_ok;
        push.sum_valid = take && end_of_buffer;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            zero_run_reg   <= '0;
            unit_open_reg  <= 1'b0;
            unit_start_reg <= '0;
            fpb_reg        <= '0;
            det_reg        <= CODEC_NONE;
            sat_reg        <= 1'b0;
            code_len_reg   <= SC_LEN_NONE;
        end
        else if (take)
        begin
            if (end_of_buffer)
            begin
                // new buffer starts from scratch
                pos_reg        <= '0;
                zero_run_reg   <= '0;
                unit_open_reg  <= 1'b0;
                unit_start_reg <= '0;
                fpb_reg        <= '0;
                det_reg        <= CODEC_NONE;
                sat_reg        <= 1'b0;
                code_len_reg   <= SC_LEN_NONE;
            end
            else
            begin
                pos_reg        <= pos_next;
                zero_run_reg   <= zero_run_next;
                unit_open_reg  <= unit_open_next;
                unit_start_reg <= unit_start_next;
                fpb_reg        <= fpb_next;
                det_reg        <= det_next;
                sat_reg        <= sat_next;
                code_len_reg   <= code_len_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/annexb_nal_unit_extractor_core.sv]
// ----------------------------------------------------------------------------
// annexb_nal_unit_extractor_core
// Annex-B start-code parser: finds NAL units in a byte stream and reports
// offset, length, start-code length, header types and a per-buffer summary.
// ----------------------------------------------------------------------------
//   channel   signals                                       dir  handshake
//   in        data_byte, end_of_buffer                       in   in_valid/in_ready
//   out       kind .. last (one result per request)          out  out_valid/out_ready
//   cfg       cfg_wr_data -> codec_select                    in   cfg_wr_en, no wait
//
// One byte per cycle while in_ready is high; results land in a 4-entry queue
// the cycle after the byte is taken. A byte yields 0, 1 or 2 results
// (record and/or summary); in_ready drops while fewer than two queue slots
// are free, so both results of a byte always find room in the queue.
// Reset (rst_n low, async) clears parser state, the queue and codec_select.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_nal_unit_extractor_core #(
    parameter int POS_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_buffer,

    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic        kind,
    output      logic [31:0] unit_offset,
    output      logic [31:0] unit_length,
    output      logic [2:0]  start_code_len,
    output      logic [4:0]  avc_type,
    output      logic [5:0]  hevc_type,
    output      logic [1:0]  codec,
    output      logic        overflow,
    output      logic        last,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data
);
    import anx_pkg::*;

    logic [1:0] codec_select_reg;

    logic        take;
    anx_push_t   push;
    anx_result_t rec_item;
    anx_result_t sum_item;
    anx_result_t first_item;
    anx_result_t head;

    anx_result_t           fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [FIFO_CNT_W-1:0] n_push;
    logic                  pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            codec_select_reg <= CODEC_NONE;
        else if (cfg_wr_en)
            codec_select_reg <= cfg_wr_data;
    end

    assign in_ready = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign take     = in_valid && in_ready;

    anx_parser #(
        .POS_BITS (POS_BITS)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .codec_select  (codec_select_reg),
        .push          (push),
        .rec_item      (rec_item),
        .sum_item      (sum_item)
    );

    always_comb
    begin
        first_item  = push.rec_valid ? rec_item : sum_item;
        n_push      = FIFO_CNT_W'(push.rec_valid) + FIFO_CNT_W'(push.sum_valid);
        pop         = out_valid && out_ready;
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + n_push - FIFO_CNT_W'(pop);
    end

    // record goes first, summary behind it
    always_ff @(posedge clk)
    begin
        if (push.rec_valid || push.sum_valid)
            fifo_mem[wr_ptr_reg] <= first_item;
        if (push.rec_valid && push.sum_valid)
            fifo_mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= sum_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head           = fifo_mem[rd_ptr_reg];
    assign out_valid      = (count_reg != '0);
    assign kind           = head.kind;
    assign unit_offset    = head.unit_offset;
    assign unit_length    = head.unit_length;
    assign start_code_len = head.start_code_len;
    assign avc_type       = head.avc_type;
    assign hevc_type      = head.hevc_type;
    assign codec          = head.codec;
    assign overflow       = head.overflow;
    assign last           = head.last;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_SUMMARY |-> last && start_code_len == SC_LEN_NONE)
        else $error("summary without last or with start code length");

    a_record_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_UNIT
        |-> (start_code_len == SC_LEN_SHORT || start_code_len == SC_LEN_LONG)
            && codec == CODEC_NONE && !overflow)
        else $error("malformed unit record");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.rec_valid || push.sum_valid |-> count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2))
        else $error("results pushed without room");
`endif

endmodule

`default_nettype wire

[bench/annexb_nal_unit_extractor_checker.sv]
// ----------------------------------------------------------------------------
// annexb_nal_unit_extractor_checker
// Watches the byte, result and register ports of the Annex-B extractor,
// predicts the unit records and buffer summaries for every accepted byte
// and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module annexb_nal_unit_extractor_checker #(
    parameter int POS_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_buffer,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        kind,
    input  logic [31:0] unit_offset,
    input  logic [31:0] unit_length,
    input  logic [2:0]  start_code_len,
    input  logic [4:0]  avc_type,
    input  logic [5:0]  hevc_type,
    input  logic [1:0]  codec,
    input  logic        overflow,
    input  logic        last,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import anx_pkg::*;

    localparam logic [63:0] POS_LIMIT = (64'd1 << POS_BITS) - 64'd1;

    // parser state
    logic [63:0] byte_idx;
    logic [63:0] unit_begin;
    logic [1:0]  zero_cnt;
    logic        unit_live;
    logic        idx_saturated;
    logic [7:0]  unit_hdr;
    logic [2:0]  unit_sc_len;
    logic [1:0]  seen_codec;
    logic [1:0]  codec_mode;

    anx_result_t expected_units[$];
    anx_result_t want;

    task report_error(input string msg);
        errors++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_field(input string name, input logic [31:0] got, input logic [31:0] exp_val);
        if (got !== exp_val)
            report_error($sformatf("%s got %0h expected %0h (offset %0h)",
                                   name, got, exp_val, want.unit_offset));
    endtask

    task clear_parser();
        byte_idx      = '0;
        unit_begin    = '0;
        zero_cnt      = '0;
        unit_live     = 1'b0;
        idx_saturated = 1'b0;
        unit_hdr      = '0;
        unit_sc_len   = SC_LEN_NONE;
        seen_codec    = CODEC_NONE;
    endtask

    // record the open unit if it holds at least one byte before stop
    task finish_unit(input logic [63:0] stop);
        logic [63:0] span;
        anx_result_t rec;
        if (unit_live && stop > unit_begin)
        begin
            span = stop - unit_begin;
            if (seen_codec == CODEC_NONE)
            begin
                if (span >= 2 && unit_hdr[6:1] >= HEVC_VPS && unit_hdr[6:1] <= HEVC_PPS)
                    seen_codec = CODEC_HEVC;
                else if (unit_hdr[4:0] == AVC_SPS || unit_hdr[4:0] == AVC_PPS)
                    seen_codec = CODEC_AVC;
            end
            rec                = '0;
            rec.kind           = KIND_UNIT;
            rec.unit_offset    = unit_begin[31:0];
            rec.unit_length    = span[31:0];
            rec.start_code_len = unit_sc_len;
            rec.avc_type       = unit_hdr[4:0];
            rec.hevc_type      = unit_hdr[6:1];
            expected_units     = {expected_units, rec};
        end
    endtask

    task predict_byte(input logic [7:0] b, input logic eob);
        logic [63:0] here;
        logic [63:0] back;
        logic [63:0] code_at;
        logic [2:0]  new_len;
        int          start_n;
        anx_result_t tail;
        here    = byte_idx;
        start_n = expected_units.size();
        if (unit_live && here == unit_begin)
            unit_hdr = b;

        if (b == SC_BYTE && zero_cnt >= 2)
        begin
            new_len = (zero_cnt == 2'd3) ? SC_LEN_LONG : SC_LEN_SHORT;
            back    = {61'd0, new_len} - 64'd1;
            code_at = (here >= back) ? here - back : 64'd0;
            finish_unit(code_at);
            unit_live   = 1'b1;
            unit_begin  = here + 64'd1;
            unit_sc_len = new_len;
            unit_hdr    = '0;
            zero_cnt    = '0;
        end
        else if (b == ZERO_BYTE)
        begin
            if (zero_cnt != 2'd3)
                zero_cnt = zero_cnt + 2'd1;
        end
        else
            zero_cnt = '0;

        if (here >= POS_LIMIT)
        begin
            byte_idx      = POS_LIMIT;
            idx_saturated = 1'b1;
        end
        else
            byte_idx = here + 64'd1;

        if (eob)
        begin
            finish_unit(here + 64'd1);
            tail      = '0;
            tail.kind = KIND_SUMMARY;
            if (codec_mode == CODEC_AVC || codec_mode == CODEC_HEVC)
                tail.codec = codec_mode;
            else if (seen_codec != CODEC_NONE)
                tail.codec = seen_codec;
            else
                tail.codec = CODEC_AVC;
            tail.overflow  = idx_saturated;
            expected_units = {expected_units, tail};
            clear_parser();
        end

        if (expected_units.size() > start_n)
        begin
            tail           = expected_units.pop_back();
            tail.last      = 1'b1;
            expected_units = {expected_units, tail};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_mode = CODEC_NONE;
            clear_parser();
            expected_units.delete();
            errors  = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_units.size() == 0)
                    report_error($sformatf("unexpected result kind %0b offset %0h",
                                           kind, unit_offset));
                else
                begin
                    want = expected_units.pop_front();
                    check_field("kind", 32'(kind), 32'(want.kind));
                    check_field("unit_offset", unit_offset, want.unit_offset);
                    check_field("unit_length", unit_length, want.unit_length);
                    check_field("start_code_len", 32'(start_code_len),
                                32'(want.start_code_len));
                    check_field("avc_type", 32'(avc_type), 32'(want.avc_type));
                    check_field("hevc_type", 32'(hevc_type), 32'(want.hevc_type));
                    check_field("codec", 32'(codec), 32'(want.codec));
                    check_field("overflow", 32'(overflow), 32'(want.overflow));
                    check_field("last", 32'(last), 32'(want.last));
                end
            end
            // a byte taken on the write edge still sees the old setting
            if (in_valid && in_ready)
                predict_byte(data_byte, end_of_buffer);
            if (cfg_wr_en)
                codec_mode = cfg_wr_data;
            pending <= expected_units.size();
        end
    end

endmodule

[bench/annexb_nal_unit_extractor_core_tb.sv]
// ----------------------------------------------------------------------------
// annexb_nal_unit_extractor_core_tb
// Drives byte buffers into the Annex-B extractor: a directed set of start
// code corner cases and random well-formed and broken buffers under each
// codec setting with random gaps and output stalls. Checking is done by the
// checker instance.
// ----------------------------------------------------------------------------
module annexb_nal_unit_extractor_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import anx_pkg::*;

    // narrower counter width than the default
    localparam int POS_BITS = 16;

    localparam logic [1:0] CODEC_SPARE = 2'd3;

    localparam logic [7:0] HDR_AVC_SPS   = {3'b011, AVC_SPS};
    localparam logic [7:0] HDR_AVC_PPS   = {3'b011, AVC_PPS};
    localparam logic [7:0] HDR_HEVC_VPS  = {1'b0, HEVC_VPS, 1'b0};
    localparam logic [7:0] HDR_HEVC_SPS  = {1'b0, HEVC_VPS + 6'd1, 1'b0};
    localparam logic [7:0] HDR_HEVC_PPS  = {1'b0, HEVC_PPS, 1'b0};
    localparam logic [7:0] HDR_PAST_PPS  = {1'b0, HEVC_PPS + 6'd1, 1'b0};
    localparam logic [7:0] HDR_BELOW_VPS = {1'b0, HEVC_VPS - 6'd1, 1'b1};

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic [7:0]  data_byte     = ZERO_BYTE;
    logic        end_of_buffer = 1'b0;
    logic        out_ready     = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [1:0]  cfg_wr_data   = CODEC_NONE;

    logic        in_ready;
    logic        out_valid;
    logic        kind;
    logic [31:0] unit_offset;
    logic [31:0] unit_length;
    logic [2:0]  start_code_len;
    logic [4:0]  avc_type;
    logic [5:0]  hevc_type;
    logic [1:0]  codec;
    logic        overflow;
    logic        last;

    int errors;
    int pending;
    int idle_pct   = 0;
    int stall_left = 0;

    logic [7:0] stream[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    annexb_nal_unit_extractor_core #(.POS_BITS(POS_BITS)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_buffer  (end_of_buffer),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .unit_offset    (unit_offset),
        .unit_length    (unit_length),
        .start_code_len (start_code_len),
        .avc_type       (avc_type),
        .hevc_type      (hevc_type),
        .codec          (codec),
        .overflow       (overflow),
        .last           (last),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    annexb_nal_unit_extractor_checker #(.POS_BITS(POS_BITS)) unit_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_buffer  (end_of_buffer),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .unit_offset    (unit_offset),
        .unit_length    (unit_length),
        .start_code_len (start_code_len),
        .avc_type       (avc_type),
        .hevc_type      (hevc_type),
        .codec          (codec),
        .overflow       (overflow),
        .last           (last),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .errors         (errors),
        .pending        (pending)
    );

    // receiver: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(99) < idle_pct / 3)
        begin
            stall_left <= $urandom_range(13);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic logic [7:0] rough_byte();
        case ($urandom_range(3))
            0:       return ZERO_BYTE;
            1:       return SC_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task push_byte(input logic [7:0] b, input logic eob);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_buffer <= eob;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task send_stream();
        int i;
        for (i = 0; i < stream.size(); i++)
            push_byte(stream[i], i == stream.size() - 1);
    endtask

    // hold off new requests until every result is out and the block is quiet
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task set_codec(input logic [1:0] sel);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sel;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task build_random_stream();
        int         shape;
        int         zeros;
        int         plen;
        logic [7:0] hdr;
        stream.delete();
        shape = $urandom_range(9);
        if (shape == 0)
        begin
            repeat ($urandom_range(12, 1)) stream = {stream, rough_byte()};
        end
        else
        begin
            // junk ahead of the first start code
            repeat ($urandom_range(2)) stream = {stream, 8'($urandom_range(255))};
            repeat ($urandom_range(4, 1))
            begin
                if (shape == 1)
                    zeros = $urandom_range(1);
                else if ($urandom_range(3) == 0)
                    zeros = $urandom_range(5, 3);
                else
                    zeros = $urandom_range(3, 2);
                repeat (zeros) stream = {stream, ZERO_BYTE};
                stream = {stream, SC_BYTE};
                plen = $urandom_range(6);
                if (plen != 0)
                begin
                    case ($urandom_range(8))
                        0:       hdr = HDR_AVC_SPS;
                        1:       hdr = HDR_AVC_PPS;
                        2:       hdr = HDR_HEVC_VPS;
                        3:       hdr = HDR_HEVC_SPS;
                        4:       hdr = HDR_HEVC_PPS;
                        5:       hdr = HDR_PAST_PPS;
                        6:       hdr = HDR_BELOW_VPS;
                        default: hdr = 8'($urandom_range(255));
                    endcase
                    stream = {stream, hdr};
                    repeat (plen - 1) stream = {stream, rough_byte()};
                end
            end
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(3, 1)) stream = {stream, ZERO_BYTE};
        end
    endtask

    task run_random(input int goal);
        int done;
        done = 0;
        while (done < goal)
        begin
            build_random_stream();
            send_stream();
            done += stream.size();
        end
    endtask

    initial
    begin
        int guard;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_codec(CODEC_NONE);
        // leading junk, 3- and 4-byte codes, one-byte VPS, extra zeros
        // folded into the previous payload
        stream = {8'hFF, ZERO_BYTE, ZERO_BYTE, SC_BYTE, HDR_HEVC_VPS,
                  ZERO_BYTE, ZERO_BYTE, ZERO_BYTE, SC_BYTE, HDR_AVC_SPS,
                  ZERO_BYTE, ZERO_BYTE, ZERO_BYTE, ZERO_BYTE, ZERO_BYTE, SC_BYTE, 8'hFF};
        send_stream();
        // single-byte buffer: summary only, fallback codec
        stream = {SC_BYTE};
        send_stream();
        // empty unit between codes, H.265 detection, buffer ending on a code
        stream = {ZERO_BYTE, ZERO_BYTE, SC_BYTE, ZERO_BYTE, ZERO_BYTE, SC_BYTE,
                  HDR_HEVC_SPS, SC_BYTE, ZERO_BYTE, ZERO_BYTE, SC_BYTE};
        send_stream();

        set_codec(CODEC_HEVC);
        idle_pct = 40;
        run_random(120);
        set_codec(CODEC_AVC);
        idle_pct = 15;
        run_random(120);
        set_codec(CODEC_SPARE);
        idle_pct = 60;
        run_random(120);
        set_codec(CODEC_NONE);
        idle_pct = 25;
        run_random(120);

        // closing stretch without idling
        idle_pct = 0;
        run_random(50);

        in_valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
